### hw/rtl/omnm_pkg.sv
`timescale 1ns / 1ps

package omnm_pkg;

    localparam int TABLE_CAPACITY = 64;
    localparam int SLOT_W         = $clog2(TABLE_CAPACITY);
    localparam int COUNT_W        = $clog2(TABLE_CAPACITY + 1);
    localparam int DIFF_W         = 25;
    localparam int SQ_W           = 2 * DIFF_W;
    localparam int DIST_W         = SQ_W + 2;
    localparam int GATE_SQ_W      = 32;

    // register indexes
    localparam logic [1:0] REG_DEFAULT_GATE = 2'd0;
    localparam logic [1:0] REG_GATE_77      = 2'd1;
    localparam logic [1:0] REG_GATE_56      = 2'd2;
    localparam logic [1:0] REG_GATE_62      = 2'd3;

    // outcome codes
    localparam logic [1:0] OUT_MERGED   = 2'd0;
    localparam logic [1:0] OUT_INSERTED = 2'd1;
    localparam logic [1:0] OUT_IGNORED  = 2'd2;
    localparam logic [1:0] OUT_FULL     = 2'd3;

    // class codes of interest
    localparam logic signed [7:0] CLS_BACKGROUND = -8'sd1;
    localparam logic signed [7:0] CLS_0  = 8'sd0;
    localparam logic signed [7:0] CLS_62 = 8'sd62;
    localparam logic signed [7:0] CLS_58 = 8'sd58;
    localparam logic signed [7:0] CLS_41 = 8'sd41;
    localparam logic signed [7:0] CLS_77 = 8'sd77;
    localparam logic signed [7:0] CLS_66 = 8'sd66;
    localparam logic signed [7:0] CLS_75 = 8'sd75;
    localparam logic signed [7:0] CLS_64 = 8'sd64;
    localparam logic signed [7:0] CLS_45 = 8'sd45;
    localparam logic signed [7:0] CLS_56 = 8'sd56;
    localparam logic signed [7:0] CLS_60 = 8'sd60;

    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic signed [7:0]  class_code;
        logic signed [23:0] centre_x;
        logic signed [23:0] centre_y;
        logic signed [23:0] centre_z;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic [15:0]        box_length;
        logic [15:0]        confidence;
    } det_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [15:0] obj_id;
        logic [5:0]  entry_slot;
    } res_t;

    typedef struct packed {
        logic signed [7:0]  class_code;
        logic signed [23:0] centre_x;
        logic signed [23:0] centre_y;
        logic signed [23:0] centre_z;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic [15:0]        box_length;
        logic [15:0]        confidence;
        logic [15:0]        obj_id;
    } ent_t;

    typedef struct packed {
        logic valid;
        ent_t ent;
    } slot_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
        logic [DIST_W-1:0] sq_dist;
        ent_t              ent;
    } best_t;

    function automatic logic is_listed(input logic signed [7:0] c);
        return c inside {CLS_BACKGROUND, CLS_0, CLS_62, CLS_58, CLS_41, CLS_77,
                         CLS_66, CLS_75, CLS_64, CLS_45, CLS_56, CLS_60};
    endfunction

endpackage

### hw/rtl/omnm_cell.sv
`timescale 1ns / 1ps

module omnm_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  logic              wr_en,
    input  omnm_pkg::slot_t   nbr,
    input  omnm_pkg::ent_t    wr_ent,
    output omnm_pkg::slot_t   q
);

    logic           valid_reg;
    logic           valid_next;
    omnm_pkg::ent_t ent_reg;
    omnm_pkg::ent_t ent_next;

    always_comb
    begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        if (wr_en)
        begin
            valid_next = 1'b1;
            ent_next   = wr_ent;
        end
        else if (shift_en)
        begin
            valid_next = nbr.valid;
            ent_next   = nbr.ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign q.valid = valid_reg;
    assign q.ent   = ent_reg;

endmodule

### hw/rtl/omnm_dist.sv
`timescale 1ns / 1ps

module omnm_dist (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          feed,
    input  omnm_pkg::det_t                query,
    input  omnm_pkg::slot_t               head,
    input  logic [omnm_pkg::SLOT_W-1:0]   head_idx,
    output omnm_pkg::best_t               best
);

    // stage 1: absolute differences
    logic                                s1_valid_reg;
    logic [omnm_pkg::SLOT_W-1:0]         s1_idx_reg;
    logic [omnm_pkg::DIFF_W-1:0]         s1_dx_reg, s1_dy_reg, s1_dz_reg;
    omnm_pkg::ent_t                      s1_ent_reg;
    // stage 2: squares
    logic                                s2_valid_reg;
    logic [omnm_pkg::SLOT_W-1:0]         s2_idx_reg;
    logic [omnm_pkg::SQ_W-1:0]           s2_qx_reg, s2_qy_reg, s2_qz_reg;
    omnm_pkg::ent_t                      s2_ent_reg;
    // stage 3: sum
    logic                                s3_valid_reg;
    logic [omnm_pkg::SLOT_W-1:0]         s3_idx_reg;
    logic [omnm_pkg::DIST_W-1:0]         s3_sum_reg;
    omnm_pkg::ent_t                      s3_ent_reg;

    omnm_pkg::best_t                     best_reg;
    omnm_pkg::best_t                     best_next;

    logic                                match;
    logic signed [omnm_pkg::DIFF_W-1:0]  dx, dy, dz;

    function automatic logic [omnm_pkg::DIFF_W-1:0] mag(
        input logic signed [omnm_pkg::DIFF_W-1:0] d);
        return d[omnm_pkg::DIFF_W-1] ? omnm_pkg::DIFF_W'(-d) : omnm_pkg::DIFF_W'(d);
    endfunction

    always_comb
    begin
        match = feed && head.valid && (head.ent.class_code == query.class_code);
        dx = {query.centre_x[23], query.centre_x} - {head.ent.centre_x[23], head.ent.centre_x};
        dy = {query.centre_y[23], query.centre_y} - {head.ent.centre_y[23], head.ent.centre_y};
        dz = {query.centre_z[23], query.centre_z} - {head.ent.centre_z[23], head.ent.centre_z};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= match;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= head_idx;
        s1_dx_reg  <= mag(dx);
        s1_dy_reg  <= mag(dy);
        s1_dz_reg  <= mag(dz);
        s1_ent_reg <= head.ent;
        s2_idx_reg <= s1_idx_reg;
        s2_qx_reg  <= s1_dx_reg * s1_dx_reg;
        s2_qy_reg  <= s1_dy_reg * s1_dy_reg;
        s2_qz_reg  <= s1_dz_reg * s1_dz_reg;
        s2_ent_reg <= s1_ent_reg;
        s3_idx_reg <= s2_idx_reg;
        s3_sum_reg <= omnm_pkg::DIST_W'(s2_qx_reg) + omnm_pkg::DIST_W'(s2_qy_reg)
                    + omnm_pkg::DIST_W'(s2_qz_reg);
        s3_ent_reg <= s2_ent_reg;
    end

    // strict compare keeps the lowest slot on a tie
    always_comb
    begin
        best_next = best_reg;
        if (start)
            best_next.found = 1'b0;
        else if (s3_valid_reg && (!best_reg.found || s3_sum_reg < best_reg.sq_dist))
        begin
            best_next.found   = 1'b1;
            best_next.idx     = s3_idx_reg;
            best_next.sq_dist = s3_sum_reg;
            best_next.ent     = s3_ent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            best_reg <= '0;
        else
            best_reg <= best_next;
    end

    assign best = best_reg;

endmodule

### hw/rtl/object_map_nearest_merge.sv
`timescale 1ns / 1ps

// channel  | handshake              | payload   | direction
// det      | det_valid / det_stall  | det_t     | detections in
// res      | res_valid / res_stall  | res_t     | one outcome per detection out
// cfg      | cfg_we                 | cfg_index, cfg_data | gate writes
//
// one detection passes a transfer cycle, a scan while the slot ring
// rotates once past the distance pipe, a drain of that pipe and a
// decide cycle that writes the chosen cell and loads the result register
// det_stall is low only in idle and high from the scan until the decide cycle completes
// reset clears slot valid bits, entry count, last id and loads the default gates
// a stalled result holds the decide cycle until the result register frees up

module object_map_nearest_merge (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             det_valid,
    output logic             det_stall,
    input  omnm_pkg::det_t   det,
    output logic             res_valid,
    input  logic             res_stall,
    output omnm_pkg::res_t   res,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    localparam int CAP = omnm_pkg::TABLE_CAPACITY;

    omnm_pkg::state_t                state_reg, state_next;
    logic [omnm_pkg::SLOT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic [1:0]                      drain_cnt_reg, drain_cnt_next;
    omnm_pkg::det_t                  query_reg;
    logic                            listed_reg;
    logic [omnm_pkg::GATE_SQ_W-1:0]  gate_sq_reg;
    logic [omnm_pkg::COUNT_W-1:0]    entry_count_reg, entry_count_next;
    logic [15:0]                     last_id_reg, last_id_next;
    logic [15:0]                     default_gate_reg, gate_77_reg, gate_56_reg, gate_62_reg;
    omnm_pkg::res_t                  res_reg, res_next;
    logic                            res_valid_reg, res_valid_next;

    logic                            accept;
    logic                            scan_en;
    logic                            go;
    logic                            scan_last;
    logic [15:0]                     gate_sel;

    omnm_pkg::best_t                 best;
    logic                            merge, ignore, full, insert;
    omnm_pkg::ent_t                  merged_ent, wr_ent;
    logic [omnm_pkg::SLOT_W-1:0]     wr_idx;
    logic                            wr_go;

    omnm_pkg::slot_t                 cell_q [CAP];
    logic [CAP-1:0]                  cell_wr;

    // ring of slot cells: cell 0 is the head the distance pipe looks at
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        omnm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (scan_en),
            .wr_en    (cell_wr[i]),
            .nbr      (cell_q[(i + 1) % CAP]),
            .wr_ent   (wr_ent),
            .q        (cell_q[i])
        );
        assign cell_wr[i] = wr_go && (wr_idx == omnm_pkg::SLOT_W'(i));
    end

    omnm_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .feed     (scan_en),
        .query    (query_reg),
        .head     (cell_q[0]),
        .head_idx (scan_cnt_reg),
        .best     (best)
    );

    assign accept    = det_valid && !det_stall;
    assign scan_last = (scan_cnt_reg == omnm_pkg::SLOT_W'(CAP - 1));

    // gate for the incoming class
    always_comb
    begin
        case (det.class_code)
            omnm_pkg::CLS_77: gate_sel = gate_77_reg;
            omnm_pkg::CLS_56: gate_sel = gate_56_reg;
            omnm_pkg::CLS_62: gate_sel = gate_62_reg;
            default:          gate_sel = default_gate_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            omnm_pkg::ST_IDLE:   if (accept) state_next = omnm_pkg::ST_SCAN;
            omnm_pkg::ST_SCAN:   if (scan_last) state_next = omnm_pkg::ST_DRAIN;
            omnm_pkg::ST_DRAIN:  if (drain_cnt_reg == omnm_pkg::DRAIN_LAST)
                                     state_next = omnm_pkg::ST_DECIDE;
            omnm_pkg::ST_DECIDE: if (go) state_next = omnm_pkg::ST_IDLE;
            default:             state_next = omnm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        det_stall = 1'b1;
        scan_en   = 1'b0;
        go        = 1'b0;
        case (state_reg)
            omnm_pkg::ST_IDLE:   det_stall = 1'b0;
            omnm_pkg::ST_SCAN:   scan_en = 1'b1;
            omnm_pkg::ST_DRAIN:  ;
            omnm_pkg::ST_DECIDE: go = !res_valid_reg || !res_stall;
            default:             ;
        endcase
    end

    // decision once the ring is back home
    always_comb
    begin
        ignore = best.found && !listed_reg;
        merge  = best.found && listed_reg
                 && (best.sq_dist < omnm_pkg::DIST_W'(gate_sq_reg));
        full   = !ignore && !merge && (entry_count_reg == omnm_pkg::COUNT_W'(CAP));
        insert = !ignore && !merge && !full;

        merged_ent            = best.ent;
        merged_ent.centre_x   = 24'((25'({best.ent.centre_x[23], best.ent.centre_x})
                                + 25'({query_reg.centre_x[23], query_reg.centre_x})) >> 1);
        merged_ent.centre_y   = 24'((25'({best.ent.centre_y[23], best.ent.centre_y})
                                + 25'({query_reg.centre_y[23], query_reg.centre_y})) >> 1);
        merged_ent.centre_z   = 24'((25'({best.ent.centre_z[23], best.ent.centre_z})
                                + 25'({query_reg.centre_z[23], query_reg.centre_z})) >> 1);
        merged_ent.box_width  = 16'((17'(best.ent.box_width) + 17'(query_reg.box_width)) >> 1);
        merged_ent.box_height = 16'((17'(best.ent.box_height) + 17'(query_reg.box_height)) >> 1);
        merged_ent.box_length = 16'((17'(best.ent.box_length) + 17'(query_reg.box_length)) >> 1);
        merged_ent.confidence = 16'((17'(best.ent.confidence) + 17'(query_reg.confidence)) >> 1);

        last_id_next     = last_id_reg;
        entry_count_next = entry_count_reg;
        res_next         = res_reg;
        wr_go            = 1'b0;
        wr_idx           = best.idx;
        wr_ent           = merged_ent;

        if (merge)
        begin
            wr_go               = go;
            res_next.outcome    = omnm_pkg::OUT_MERGED;
            res_next.obj_id     = best.ent.obj_id;
            res_next.entry_slot = 6'(best.idx);
        end
        else if (insert)
        begin
            wr_go                = go;
            wr_idx               = entry_count_reg[omnm_pkg::SLOT_W-1:0];
            wr_ent.class_code    = query_reg.class_code;
            wr_ent.centre_x      = query_reg.centre_x;
            wr_ent.centre_y      = query_reg.centre_y;
            wr_ent.centre_z      = query_reg.centre_z;
            wr_ent.box_width     = query_reg.box_width;
            wr_ent.box_height    = query_reg.box_height;
            wr_ent.box_length    = query_reg.box_length;
            wr_ent.confidence    = query_reg.confidence;
            wr_ent.obj_id        = last_id_reg + 16'd1;
            res_next.outcome     = omnm_pkg::OUT_INSERTED;
            res_next.obj_id      = last_id_reg + 16'd1;
            res_next.entry_slot  = 6'(entry_count_reg[omnm_pkg::SLOT_W-1:0]);
            if (go)
            begin
                last_id_next     = last_id_reg + 16'd1;
                entry_count_next = entry_count_reg + omnm_pkg::COUNT_W'(1);
            end
        end
        else
        begin
            res_next.outcome    = ignore ? omnm_pkg::OUT_IGNORED : omnm_pkg::OUT_FULL;
            res_next.obj_id     = 16'd0;
            res_next.entry_slot = 6'd0;
        end

        if (!go)
            res_next = res_reg;

        res_valid_next = res_valid_reg;
        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        if (go)
            res_valid_next = 1'b1;
    end

    // counters
    always_comb
    begin
        scan_cnt_next  = scan_cnt_reg;
        drain_cnt_next = drain_cnt_reg;
        if (accept)
            scan_cnt_next = '0;
        else if (scan_en)
            scan_cnt_next = scan_last ? '0 : scan_cnt_reg + omnm_pkg::SLOT_W'(1);
        if (state_reg != omnm_pkg::ST_DRAIN)
            drain_cnt_next = 2'd0;
        else
            drain_cnt_next = drain_cnt_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= omnm_pkg::ST_IDLE;
            scan_cnt_reg     <= '0;
            drain_cnt_reg    <= 2'd0;
            entry_count_reg  <= '0;
            last_id_reg      <= 16'd0;
            res_valid_reg    <= 1'b0;
            default_gate_reg <= 16'd600;
            gate_77_reg      <= 16'd60;
            gate_56_reg      <= 16'd500;
            gate_62_reg      <= 16'd250;
        end
        else
        begin
            state_reg       <= state_next;
            scan_cnt_reg    <= scan_cnt_next;
            drain_cnt_reg   <= drain_cnt_next;
            entry_count_reg <= entry_count_next;
            last_id_reg     <= last_id_next;
            res_valid_reg   <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    omnm_pkg::REG_DEFAULT_GATE: default_gate_reg <= cfg_data;
                    omnm_pkg::REG_GATE_77:      gate_77_reg      <= cfg_data;
                    omnm_pkg::REG_GATE_56:      gate_56_reg      <= cfg_data;
                    omnm_pkg::REG_GATE_62:      gate_62_reg      <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    // detection and its gate squared, taken at the transfer
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            query_reg   <= det;
            listed_reg  <= omnm_pkg::is_listed(det.class_code);
            gate_sq_reg <= gate_sel * gate_sel;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // table never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= omnm_pkg::COUNT_W'(CAP))
        else $error("entry count beyond capacity");

    // ring is at its home rotation whenever cells are written
    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == omnm_pkg::ST_DECIDE |-> scan_cnt_reg == '0)
        else $error("ring not home at decide");

    // a result only appears from a decide cycle
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == omnm_pkg::ST_DECIDE))
        else $error("result without decide");

    // an insert advances count and id together
    a_insert_step: assert property (@(posedge clk) disable iff (!rst_n)
        go && insert |=> (entry_count_reg == $past(entry_count_reg) + omnm_pkg::COUNT_W'(1))
                         && (last_id_reg == $past(last_id_reg) + 16'd1))
        else $error("insert bookkeeping slip");

endmodule

### tb/object_map_nearest_merge_test.sv
`timescale 1ns / 1ps

module object_map_nearest_merge_test;
    import omnm_pkg::*;

    // scoreboard: own copy of the map table and gates, one predicted outcome per detection
    class map_scoreboard;
        logic [15:0]        gate_default, gate_77, gate_56, gate_62;
        logic               valid_q [TABLE_CAPACITY];
        det_t               entry_q [TABLE_CAPACITY];
        logic [15:0]        id_q [TABLE_CAPACITY];
        int                 count;
        logic [15:0]        last_id;
        res_t               pending [$];
        int                 errors;
        int                 n_checked;
        int                 n_by_outcome [4];

        function void clear();
            gate_default = 16'd600;
            gate_77 = 16'd60;
            gate_56 = 16'd500;
            gate_62 = 16'd250;
            foreach (valid_q[i]) valid_q[i] = 1'b0;
            count = 0;
            last_id = '0;
            pending.delete();
            errors = 0;
            n_checked = 0;
        endfunction

        function void set_gate(logic [1:0] idx, logic [15:0] v);
            case (idx)
                REG_DEFAULT_GATE: gate_default = v;
                REG_GATE_77:      gate_77 = v;
                REG_GATE_56:      gate_56 = v;
                default:          gate_62 = v;
            endcase
        endfunction

        function logic signed [23:0] floor_half(logic signed [23:0] a, logic signed [23:0] b);
            logic signed [24:0] s;
            s = 25'(a) + 25'(b);
            return s >>> 1;
        endfunction

        function longint unsigned sq(logic signed [23:0] a, logic signed [23:0] b);
            longint d;
            d = longint'(a) - longint'(b);
            if (d < 0) d = -d;
            return d * d;
        endfunction

        function void note_detection(det_t d);
            bit found, listed, merge;
            int best;
            longint unsigned best_d, sum_d, g;
            res_t r;
            found = 0; best = 0; best_d = 0;
            for (int i = 0; i < TABLE_CAPACITY; i++)
            begin
                if (!valid_q[i] || entry_q[i].class_code != d.class_code) continue;
                sum_d = sq(d.centre_x, entry_q[i].centre_x) + sq(d.centre_y, entry_q[i].centre_y)
                      + sq(d.centre_z, entry_q[i].centre_z);
                if (!found || sum_d < best_d)
                begin
                    found = 1; best = i; best_d = sum_d;
                end
            end
            listed = d.class_code inside {CLS_BACKGROUND, CLS_0, CLS_62, CLS_58, CLS_41,
                                          CLS_77, CLS_66, CLS_75, CLS_64, CLS_45, CLS_56, CLS_60};
            r = '0;
            if (found && !listed)
                r.outcome = OUT_IGNORED;
            else
            begin
                merge = 0;
                if (found)
                begin
                    g = gate_default;
                    if (d.class_code == CLS_77) g = gate_77;
                    else if (d.class_code == CLS_56) g = gate_56;
                    else if (d.class_code == CLS_62) g = gate_62;
                    merge = best_d < g * g;
                end
                if (merge)
                begin
                    entry_q[best].centre_x = floor_half(entry_q[best].centre_x, d.centre_x);
                    entry_q[best].centre_y = floor_half(entry_q[best].centre_y, d.centre_y);
                    entry_q[best].centre_z = floor_half(entry_q[best].centre_z, d.centre_z);
                    entry_q[best].box_width = 16'((17'(entry_q[best].box_width) + d.box_width) >> 1);
                    entry_q[best].box_height =
                        16'((17'(entry_q[best].box_height) + d.box_height) >> 1);
                    entry_q[best].box_length =
                        16'((17'(entry_q[best].box_length) + d.box_length) >> 1);
                    entry_q[best].confidence =
                        16'((17'(entry_q[best].confidence) + d.confidence) >> 1);
                    r.outcome = OUT_MERGED;
                    r.obj_id = id_q[best];
                    r.entry_slot = 6'(best);
                end
                else if (count >= TABLE_CAPACITY)
                    r.outcome = OUT_FULL;
                else
                begin
                    last_id = last_id + 16'd1;
                    valid_q[count] = 1'b1;
                    entry_q[count] = d;
                    id_q[count] = last_id;
                    r.outcome = OUT_INSERTED;
                    r.obj_id = last_id;
                    r.entry_slot = 6'(count);
                    count++;
                end
            end
            pending = {pending, r};
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result outcome=%0d id=%0d slot=%0d",
                         $time, got.outcome, got.obj_id, got.entry_slot);
                errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            n_by_outcome[got.outcome]++;
            if (got.outcome !== want.outcome)
            begin
                $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, got.outcome);
                errors++;
            end
            if (got.obj_id !== want.obj_id)
            begin
                $display("%0t: id expected %0d actual %0d",
                         $time, want.obj_id, got.obj_id);
                errors++;
            end
            if (got.entry_slot !== want.entry_slot)
            begin
                $display("%0t: entry_slot expected %0d actual %0d",
                         $time, want.entry_slot, got.entry_slot);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        det_valid;
    logic        det_stall;
    det_t        det;
    logic        res_valid;
    logic        res_stall;
    res_t        res;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    map_scoreboard board;
    bit          long_hold;        // receiver holds off for a long stretch
    int          sent;

    object_map_nearest_merge DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .det_valid (det_valid),
        .det_stall (det_stall),
        .det       (det),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard limit, far above the slowest correct run
    initial
    begin
        #20ms;
        $display("** object_map_nearest_merge: FAILED **");
        $finish;
    end

    // every accepted input transfer is noted at the rising edge
    always @(posedge clk)
        if (rst_n && det_valid && !det_stall)
            board.note_detection(det);

    // every accepted result transfer is checked at the rising edge
    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            board.check_result(res);

    // receiver: one random hold-off per result, drawn when it shows up
    initial
    begin
        int gap;
        bit drawn;
        bit xfer;
        gap = 0;
        drawn = 1'b0;
        res_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            xfer = res_valid && !res_stall;
            @(negedge clk);
            if (xfer)
                drawn = 1'b0;
            if (long_hold)
                res_stall = 1'b1;
            else if (res_valid && !drawn)
            begin
                gap = $urandom_range(0, 11);
                drawn = 1'b1;
                res_stall = (gap > 0);
            end
            else if (gap > 0)
            begin
                gap--;
                res_stall = (gap > 0);
            end
            else
                res_stall = 1'b0;
        end
    end

    // offer one detection, wait out a random gap first when idle is set
    task automatic send_detection(det_t d, bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 11) : 0;
        repeat (gap) @(negedge clk);
        det = d;
        det_valid = 1'b1;
        do @(posedge clk); while (det_stall);
        @(negedge clk);
        det_valid = 1'b0;
        det = det_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        sent++;
    endtask

    task automatic wait_idle();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_gate(logic [1:0] idx, logic [15:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        board.set_gate(idx, v);
    endtask

    function automatic logic signed [7:0] pick_class();
        logic signed [7:0] listed [12] = '{CLS_BACKGROUND, CLS_0, CLS_62, CLS_58, CLS_41,
                                          CLS_77, CLS_66, CLS_75, CLS_64, CLS_45, CLS_56, CLS_60};
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return listed[$urandom_range(0, 11)];
        if (r < 8) return 8'($urandom);
        return 8'($urandom_range(1, 3) * 10 + 1);   // a few unlisted classes that repeat
    endfunction

    // random detection, often close to a recent one so merges happen
    function automatic det_t random_det(det_t near, bit use_near, int spread);
        det_t d;
        d = det_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        d.class_code = pick_class();
        if (use_near)
        begin
            d.class_code = near.class_code;
            d.centre_x = near.centre_x + 24'($signed($urandom_range(0, 2 * spread)) - spread);
            d.centre_y = near.centre_y + 24'($signed($urandom_range(0, 2 * spread)) - spread);
            d.centre_z = near.centre_z + 24'($signed($urandom_range(0, 2 * spread)) - spread);
        end
        else if ($urandom_range(0, 3) != 0)
        begin
            d.centre_x = 24'($signed($urandom_range(0, 20000)) - 10000);
            d.centre_y = 24'($signed($urandom_range(0, 20000)) - 10000);
            d.centre_z = 24'($signed($urandom_range(0, 4000)) - 2000);
        end
        return d;
    endfunction

    function automatic det_t make_det(logic signed [7:0] c, logic signed [23:0] x,
                                      logic signed [23:0] y, logic signed [23:0] z, logic [15:0] s);
        det_t d;
        d.class_code = c;
        d.centre_x = x;
        d.centre_y = y;
        d.centre_z = z;
        d.box_width = s;
        d.box_height = ~s;
        d.box_length = s ^ 16'h5a5a;
        d.confidence = s + 16'd1;
        return d;
    endfunction

    initial
    begin
        det_t prev, d;
        board = new();
        board.clear();
        rst_n = 1'b0;
        det_valid = 1'b0;
        det = '0;
        prev = '0;
        cfg_we = 1'b0;
        cfg_index = REG_DEFAULT_GATE;
        cfg_data = '0;
        long_hold = 1'b0;
        sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: inserts, merge in and out of gate, extremes, ties, unlisted class
        send_detection(make_det(CLS_BACKGROUND, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 16'hffff), 0);
        send_detection(make_det(CLS_BACKGROUND, 24'sh7fffff, 24'sh7ffffe, 24'sh7fffff, 16'h0000), 0);
        send_detection(make_det(CLS_0, -24'sd8388608, -24'sd8388608, -24'sd8388608, 16'h0), 0);
        send_detection(make_det(CLS_0, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 16'hffff), 0);
        send_detection(make_det(CLS_0, -24'sd8388607, -24'sd8388608, -24'sd8388608, 16'h1), 0);
        send_detection(make_det(CLS_77, 0, 0, 0, 16'h1234), 0);
        send_detection(make_det(CLS_77, 59, 0, 0, 16'h4321), 0);     // just inside its gate
        send_detection(make_det(CLS_77, 0, 60, 0, 16'h0001), 0);     // beyond its gate, so inserted
        send_detection(make_det(CLS_56, 100, 100, 100, 16'h8000), 0);
        send_detection(make_det(CLS_56, -199, 100, 100, 16'h7fff), 0);
        send_detection(make_det(CLS_62, -5, -5, -5, 16'h00ff), 0);
        send_detection(make_det(CLS_62, -6, -5, -5, 16'hff00), 0);
        send_detection(make_det(8'sd127, 10, 10, 10, 16'h3), 0);
        send_detection(make_det(8'sd127, 10, 10, 10, 16'h4), 0);      // unlisted, ignored
        send_detection(make_det(-8'sd128, 1, 2, 3, 16'h5), 0);
        send_detection(make_det(CLS_58, 1000, 0, 0, 16'h6), 0);
        send_detection(make_det(CLS_58, -1000, 0, 0, 16'h7), 0);
        send_detection(make_det(CLS_58, 0, 0, 0, 16'h8), 0);          // tie, but beyond the gate, so inserted
        wait_idle();

        // gates at the extremes
        write_gate(REG_DEFAULT_GATE, 16'hffff);
        write_gate(REG_GATE_77, 16'h0000);
        write_gate(REG_GATE_56, 16'hffff);
        write_gate(REG_GATE_62, 16'h0000);
        send_detection(make_det(CLS_77, 0, 0, 0, 16'h9), 0);          // zero gate never merges
        send_detection(make_det(CLS_62, -5, -5, -5, 16'ha), 0);
        send_detection(make_det(CLS_0, 24'sh7fffff, 24'sh7fffff, 24'sh7fff00, 16'hb), 0);
        send_detection(make_det(CLS_56, 50000, 0, 0, 16'hc), 0);
        wait_idle();

        // random phases with different gate settings; fills the table part way through
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 3)
            begin
                // rebuild a fresh view is not possible without reset, so keep the full table
                write_gate(REG_DEFAULT_GATE, 16'd2000);
                write_gate(REG_GATE_77, 16'd300);
                write_gate(REG_GATE_56, 16'd1);
                write_gate(REG_GATE_62, 16'd65535);
            end
            else if (phase > 0)
                write_gate(2'($urandom_range(0, 3)), 16'($urandom_range(0, 3000)));
            for (int n = 0; n < 310; n++)
            begin
                bit near;
                near = sent > 0 && $urandom_range(0, 2) != 0;
                d = random_det(prev, near, $urandom_range(0, 1) ? 40 : 400);
                if (phase == 1 && n == 100)
                    fork
                        begin
                            long_hold = 1'b1;
                            repeat (600) @(negedge clk);
                            long_hold = 1'b0;
                        end
                    join_none
                send_detection(d, ($urandom_range(0, 4) != 0));
                if (!near || $urandom_range(0, 3) == 0) prev = d;
            end
            wait_idle();
        end

        $display("ran %0d detections, %0d results: merged %0d inserted %0d ignored %0d full %0d",
                 sent, board.n_checked, board.n_by_outcome[0], board.n_by_outcome[1],
                 board.n_by_outcome[2], board.n_by_outcome[3]);
        $display("table held %0d entries, all four gates written incl. 0 and 65535",
                 board.count);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("** object_map_nearest_merge: PASSED **");
        else
            $display("** object_map_nearest_merge: FAILED **");
        $finish;
    end

endmodule
